/* sv/rarmt_pkg.sv */
// shared types, widths and helpers for the range add / range max tree
// no dependencies; used by rarmt_node_ram and range_add_range_max_tree
`timescale 1ns / 1ps
package rarmt_pkg;

   localparam int LEAVES_DEF     = 1024;   // default leaf count
   localparam int VAL_W          = 64;     // node value width
   localparam int SIZE_W         = 11;     // range_size register width
   localparam int LO_W           = 10;     // range_lo width
   localparam int HI_W           = 11;     // range_hi width
   localparam int REQ_TDATA_W    = 88;     // lo + hi + delta, padded to bytes
   localparam int RSP_TUSER_W    = 2;      // status, was_query
   localparam int RANGE_SIZE_RST = 1024;   // range_size after reset

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic STAT_DONE   = 1'b0;
   localparam logic STAT_REJECT = 1'b1;

   // one tree node: subtree maximum and add pending for the children
   typedef struct packed {
      logic [VAL_W-1:0] max_val;
      logic [VAL_W-1:0] pend;
   } node_type;

   // signed maximum of two two's complement words
   function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
      return ($signed(a) > $signed(b)) ? a : b;
   endfunction

endpackage

/* sv/rarmt_node_ram.sv */
// node store of the tree: one write port, one read port, registered read data
// depends on rarmt_pkg for the node word type
`timescale 1ns / 1ps
module rarmt_node_ram #(
   parameter int DEPTH = 2 * rarmt_pkg::LEAVES_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  rarmt_pkg::node_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output rarmt_pkg::node_type        rd_data
);

   rarmt_pkg::node_type mem [DEPTH];
   rarmt_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/range_add_range_max_tree.sv */
// top level of the range add / range max lazy segment tree
// depends on rarmt_pkg and rarmt_node_ram
`timescale 1ns / 1ps

// Lazy segment tree over positions 0 .. range_size-1, each a signed 64-bit
// value that starts at zero. An add word (tuser 0) adds delta to every
// position in [range_lo, range_hi); a query word (tuser 1) returns the
// maximum over that range. Sums wrap at 64 bits. Empty ranges or ranges
// past range_size come back at once with status 1 and leave the tree alone.
// One item is worked at a time by a sequencer that walks the tree with an
// explicit call stack and keeps every node in a single-port-read,
// single-port-write memory of 2*LEAVES words. Each node visit costs a
// registered read plus its writes: a fully covered node is read and then
// updated or handed back, a split node does the push-down of a pending add,
// the two child calls, and for adds the re-read of both children. Up to
// about four nodes are visited per level. Rejected items skip the tree walk.
// After reset and after every csr write the memory is cleared in a pass
// over all 2*LEAVES words, during which no request word is taken. A
// finished result sits in an output register, so the next request is
// taken while it waits.
module range_add_range_max_tree #(
   parameter int LEAVES = rarmt_pkg::LEAVES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = range_lo[9:0], range_hi[20:10], delta[84:21], zero pad
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rarmt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // request: tuser = action
   input  logic                                req_tuser,
   // response: tdata = max_value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rarmt_pkg::VAL_W-1:0]         rsp_tdata,
   // response: tuser = status[0], was_query[1]
   output logic [rarmt_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   // range_size register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rarmt_pkg::SIZE_W-1:0]        csr_wdata
);

   localparam int NODES = 2 * LEAVES;
   localparam int AW    = $clog2(NODES);          // memory address width
   localparam int NW    = AW + 2;                 // node number width
   localparam int PW    = $clog2(LEAVES + 1);     // position width
   localparam int SD    = $clog2(LEAVES) + 1;     // call stack depth
   localparam int TW    = (SD > 1) ? $clog2(SD) : 1;
   localparam int VW    = rarmt_pkg::VAL_W;
   localparam int SIZE_RST = (rarmt_pkg::RANGE_SIZE_RST > LEAVES) ?
                             LEAVES : rarmt_pkg::RANGE_SIZE_RST;

   // one-hot sequencer states
   typedef enum logic [13:0] {
      ST_CLEAR = 14'b00000000000001,
      ST_IDLE  = 14'b00000000000010,
      ST_CALL  = 14'b00000000000100,
      ST_FULL  = 14'b00000000001000,
      ST_PD    = 14'b00000000010000,
      ST_PDL   = 14'b00000000100000,
      ST_PDR   = 14'b00000001000000,
      ST_PDZ   = 14'b00000010000000,
      ST_DESC  = 14'b00000100000000,
      ST_CMBL  = 14'b00001000000000,
      ST_CMBR  = 14'b00010000000000,
      ST_RET   = 14'b00100000000000,
      ST_RETW  = 14'b01000000000000,
      ST_DONE  = 14'b10000000000000
   } state_type;

   // where a frame stands: before left child, after left, after right
   typedef enum logic [1:0] {
      PH_LEFT  = 2'd0,
      PH_RIGHT = 2'd1,
      PH_JOIN  = 2'd2
   } phase_type;

   state_type state_ff, state_in;

   // request fields
   logic [rarmt_pkg::LO_W-1:0] req_lo;
   logic [rarmt_pkg::HI_W-1:0] req_hi;
   logic [VW-1:0]              req_delta;
   logic                       req_fire;
   logic                       req_reject;

   assign req_lo    = req_tdata[rarmt_pkg::LO_W-1:0];
   assign req_hi    = req_tdata[rarmt_pkg::LO_W +: rarmt_pkg::HI_W];
   assign req_delta = req_tdata[rarmt_pkg::LO_W + rarmt_pkg::HI_W +: VW];

   // config and item registers
   logic [PW-1:0] size_ff;
   logic [AW-1:0] clr_ff;
   logic          act_ff;
   logic [VW-1:0] delta_ff;
   logic          rej_ff;
   logic [VW-1:0] ret_ff;     // value handed back by the frame just finished
   logic [VW-1:0] p_ff;       // pending add being pushed down
   logic [VW-1:0] nmax_ff;    // max of the node being pushed down
   logic [VW-1:0] cl_ff;      // left child max while recombining
   logic          rd_ok_ff;   // last read address lay inside the store

   // call stack, read only at the top
   logic [NW-1:0] stk_n_ff  [SD];
   logic [PW-1:0] stk_s_ff  [SD];
   logic [PW-1:0] stk_e_ff  [SD];
   logic [PW-1:0] stk_l_ff  [SD];
   logic [PW-1:0] stk_r_ff  [SD];
   phase_type     stk_ph_ff [SD];
   logic [VW-1:0] stk_lv_ff [SD];
   logic [VW-1:0] stk_rv_ff [SD];
   logic [TW-1:0] tp_ff;

   // response register
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_max_ff;
   logic          rsp_stat_ff;
   logic          rsp_q_ff;

   // top frame view
   logic [NW-1:0] t_n, c_left, c_right;
   logic [PW-1:0] t_s, t_e, t_l, t_r, t_mid;
   phase_type     t_ph;
   logic [PW:0]   mid_sum;
   logic          t_full;

   assign t_n     = stk_n_ff[tp_ff];
   assign t_s     = stk_s_ff[tp_ff];
   assign t_e     = stk_e_ff[tp_ff];
   assign t_l     = stk_l_ff[tp_ff];
   assign t_r     = stk_r_ff[tp_ff];
   assign t_ph    = stk_ph_ff[tp_ff];
   assign mid_sum = {1'b0, t_s} + {1'b0, t_e};
   assign t_mid   = mid_sum[PW:1];
   assign c_left  = {t_n[NW-2:0], 1'b0};
   assign c_right = {t_n[NW-2:0], 1'b1};
   assign t_full  = (t_l == t_s) && (t_r == t_e);

   // node store
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   rarmt_pkg::node_type wr_data;
   logic [NW-1:0]       wr_node;
   logic [AW-1:0]       rd_addr;
   logic [NW-1:0]       rd_node;
   logic                rd_ok;
   rarmt_pkg::node_type ram_rd;
   rarmt_pkg::node_type rdat;      // read data, zero beyond the store

   rarmt_node_ram #(
      .DEPTH(NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign rdat = rd_ok_ff ? ram_rd : '0;

   // handshakes
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;
   assign req_reject = ({1'b0, req_lo} >= req_hi) ||
                       (32'(req_hi) > 32'(size_ff));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_max_ff;
   assign rsp_tuser  = {rsp_q_ff, rsp_stat_ff};

   // clamped register value
   logic [31:0] csr_clamp;
   always_comb begin
      csr_clamp = 32'(csr_wdata);
      if (csr_clamp == 32'd0) begin
         csr_clamp = 32'd1;
      end
      if (csr_clamp > 32'(LEAVES)) begin
         csr_clamp = 32'(LEAVES);
      end
   end

   // memory access and next state
   always_comb begin
      state_in = state_ff;
      wr_en    = 1'b0;
      wr_node  = t_n;
      wr_data  = '0;
      rd_node  = t_n;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = req_reject ? ST_DONE : ST_CALL;
            end
         end
         ST_CALL: begin
            rd_node  = t_n;
            state_in = t_full ? ST_FULL : ST_PD;
         end
         ST_FULL: begin
            // fully covered node: apply the add here, or hand back its max
            if (act_ff == rarmt_pkg::ACT_ADD) begin
               wr_en           = 1'b1;
               wr_node         = t_n;
               wr_data.max_val = rdat.max_val + delta_ff;
               wr_data.pend    = rdat.pend + delta_ff;
            end
            state_in = ST_RET;
         end
         ST_PD: begin
            rd_node  = c_left;
            state_in = (rdat.pend != '0) ? ST_PDL : ST_DESC;
         end
         ST_PDL: begin
            wr_en           = 1'b1;
            wr_node         = c_left;
            wr_data.max_val = rdat.max_val + p_ff;
            wr_data.pend    = rdat.pend + p_ff;
            rd_node         = c_right;
            state_in        = ST_PDR;
         end
         ST_PDR: begin
            wr_en           = 1'b1;
            wr_node         = c_right;
            wr_data.max_val = rdat.max_val + p_ff;
            wr_data.pend    = rdat.pend + p_ff;
            state_in        = ST_PDZ;
         end
         ST_PDZ: begin
            wr_en           = 1'b1;
            wr_node         = t_n;
            wr_data.max_val = nmax_ff;
            wr_data.pend    = '0;
            state_in        = ST_DESC;
         end
         ST_DESC: begin
            case (t_ph)
               PH_LEFT: begin
                  if (t_l < t_mid) begin
                     state_in = ST_CALL;
                  end
               end
               PH_RIGHT: begin
                  if (t_r > t_mid) begin
                     state_in = ST_CALL;
                  end
               end
               default: begin
                  if (act_ff == rarmt_pkg::ACT_ADD) begin
                     rd_node  = c_left;
                     state_in = ST_CMBL;
                  end else begin
                     state_in = ST_RET;
                  end
               end
            endcase
         end
         ST_CMBL: begin
            rd_node  = c_right;
            state_in = ST_CMBR;
         end
         ST_CMBR: begin
            // after a push-down the node's own pending add is always zero
            wr_en           = 1'b1;
            wr_node         = t_n;
            wr_data.max_val = rarmt_pkg::smax(cl_ff, rdat.max_val);
            wr_data.pend    = '0;
            state_in        = ST_RET;
         end
         ST_RET: begin
            state_in = (tp_ff == '0) ? ST_DONE : ST_RETW;
         end
         ST_RETW: begin
            state_in = ST_DESC;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         // nodes beyond the store drop their writes
         wr_en   = wr_en && (wr_node < NW'(NODES));
         wr_addr = wr_node[AW-1:0];
      end
      if (csr_valid) begin
         state_in = ST_CLEAR;
      end
   end

   assign rd_ok   = rd_node < NW'(NODES);
   assign rd_addr = rd_node[AW-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         size_ff      <= PW'(SIZE_RST);
         rsp_valid_ff <= 1'b0;
         tp_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            size_ff <= PW'(csr_clamp);
            clr_ff  <= '0;
         end else if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (state_ff == ST_IDLE && req_fire) begin
            tp_ff <= '0;
         end else if (state_ff == ST_DESC && state_in == ST_CALL) begin
            tp_ff <= tp_ff + TW'(1);
         end else if (state_ff == ST_RET && tp_ff != '0) begin
            tp_ff <= tp_ff - TW'(1);
         end
         if (state_ff == ST_DONE && state_in == ST_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_ok;
      case (state_ff)
         ST_IDLE: begin
            act_ff   <= req_tuser;
            delta_ff <= req_delta;
            rej_ff   <= req_reject;
            ret_ff   <= '0;
            // root frame over the whole tree
            stk_n_ff[0]  <= NW'(1);
            stk_s_ff[0]  <= '0;
            stk_e_ff[0]  <= size_ff;
            stk_l_ff[0]  <= PW'(req_lo);
            stk_r_ff[0]  <= PW'(req_hi);
            stk_ph_ff[0] <= PH_LEFT;
         end
         ST_FULL: begin
            ret_ff <= (act_ff == rarmt_pkg::ACT_QUERY) ? rdat.max_val : '0;
         end
         ST_PD: begin
            p_ff    <= rdat.pend;
            nmax_ff <= rdat.max_val;
         end
         ST_DESC: begin
            case (t_ph)
               PH_LEFT: begin
                  stk_ph_ff[tp_ff] <= PH_RIGHT;
                  if (t_l < t_mid) begin
                     stk_n_ff[tp_ff + TW'(1)]  <= c_left;
                     stk_s_ff[tp_ff + TW'(1)]  <= t_s;
                     stk_e_ff[tp_ff + TW'(1)]  <= t_mid;
                     stk_l_ff[tp_ff + TW'(1)]  <= t_l;
                     stk_r_ff[tp_ff + TW'(1)]  <= (t_r < t_mid) ? t_r : t_mid;
                     stk_ph_ff[tp_ff + TW'(1)] <= PH_LEFT;
                  end
               end
               PH_RIGHT: begin
                  stk_ph_ff[tp_ff] <= PH_JOIN;
                  if (t_r > t_mid) begin
                     stk_n_ff[tp_ff + TW'(1)]  <= c_right;
                     stk_s_ff[tp_ff + TW'(1)]  <= t_mid;
                     stk_e_ff[tp_ff + TW'(1)]  <= t_e;
                     stk_l_ff[tp_ff + TW'(1)]  <= (t_l > t_mid) ? t_l : t_mid;
                     stk_r_ff[tp_ff + TW'(1)]  <= t_r;
                     stk_ph_ff[tp_ff + TW'(1)] <= PH_LEFT;
                  end
               end
               default: begin
                  // query: combine the parts that were visited
                  if (t_r <= t_mid) begin
                     ret_ff <= stk_lv_ff[tp_ff];
                  end else if (t_l >= t_mid) begin
                     ret_ff <= stk_rv_ff[tp_ff];
                  end else begin
                     ret_ff <= rarmt_pkg::smax(stk_lv_ff[tp_ff], stk_rv_ff[tp_ff]);
                  end
               end
            endcase
         end
         ST_CMBL: begin
            cl_ff <= rdat.max_val;
         end
         ST_CMBR: begin
            ret_ff <= '0;
         end
         ST_RETW: begin
            // parent's phase tells which child just returned
            if (t_ph == PH_RIGHT) begin
               stk_lv_ff[tp_ff] <= ret_ff;
            end else begin
               stk_rv_ff[tp_ff] <= ret_ff;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_max_ff  <= (rej_ff || act_ff == rarmt_pkg::ACT_ADD) ? '0 : ret_ff;
               rsp_stat_ff <= rej_ff ? rarmt_pkg::STAT_REJECT : rarmt_pkg::STAT_DONE;
               rsp_q_ff    <= act_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
